// File: rtl/core/min_tracking_stack_core_assert.svh
// Assertion macros shared by the min stack RTL.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define MSK_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MSK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define MSK_ASSERT(label, prop)
`define MSK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: rtl/core/msk_pkg.sv
// Shared types and constants for the min stack core.
// Depends on nothing; used by the interfaces and every module.
package msk_pkg;

    localparam int DATA_W          = 32;
    localparam int STACK_DEPTH_DEF = 128;

    // Operation codes.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the incoming word
        logic exec;      // apply the operation to counts and stores
        logic load;      // take refetched tops from the memories
        logic emit;      // load the output register
    } msk_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic refetch;   // a pop succeeded, tops must be reread
    } msk_sts_t;

endpackage

// File: rtl/core/msk_req_if.sv
// Request channel interface of the min stack core.
// Depends on msk_pkg.
interface msk_req_if import msk_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic                     operation;
    logic signed [DATA_W-1:0] push_value;

    modport source (output valid, operation, push_value, input ready);
    modport sink   (input valid, operation, push_value, output ready);

endinterface

// File: rtl/core/msk_rsp_if.sv
// Response channel interface of the min stack core.
// Depends on msk_pkg.
interface msk_rsp_if import msk_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] top_value;
    logic signed [DATA_W-1:0] min_value;
    logic                     is_empty;
    logic [1:0]               status;

    modport source (output valid, top_value, min_value, is_empty, status, input ready);
    modport sink   (input valid, top_value, min_value, is_empty, status, output ready);

endinterface

// File: rtl/core/msk_datapath.sv
// Datapath of the min stack: value and minimum memories, counts, cached tops.
// Depends on msk_pkg and min_tracking_stack_core_assert.svh.
`include "min_tracking_stack_core_assert.svh"

module msk_datapath import msk_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  msk_cmd_t                 cmd,
    output msk_sts_t                 sts,
    input  logic                     operation,
    input  logic signed [DATA_W-1:0] push_value,
    output logic signed [DATA_W-1:0] top_value,
    output logic signed [DATA_W-1:0] min_value,
    output logic                     is_empty,
    output logic [1:0]               status
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    logic signed [DATA_W-1:0] value_mem [STACK_DEPTH];
    logic signed [DATA_W-1:0] min_mem   [STACK_DEPTH];

    logic                     op_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [CW-1:0]            value_count_reg, value_count_next;
    logic [CW-1:0]            min_count_reg, min_count_next;
    logic signed [DATA_W-1:0] top_reg, min_top_reg;
    logic signed [DATA_W-1:0] val_rd_reg, min_rd_reg;
    logic [1:0]               status_reg;
    logic signed [DATA_W-1:0] top_out_reg, min_out_reg;
    logic                     empty_out_reg;
    logic [1:0]               status_out_reg;

    logic          full, empty, min_empty;
    logic          push_ok, push_min, pop_ok, pop_min;
    logic [CW-1:0] val_rd_count, min_rd_count;

    always_comb
    begin
        full      = (value_count_reg == FULL_COUNT);
        empty     = (value_count_reg == '0);
        min_empty = (min_count_reg == '0);
        push_ok   = (op_reg == OP_PUSH) && !full;
        push_min  = push_ok && (min_empty || (val_reg <= min_top_reg)) &&
                    (min_count_reg != FULL_COUNT);
        pop_ok    = (op_reg == OP_POP) && !empty;
        pop_min   = pop_ok && !min_empty && (top_reg == min_top_reg);

        value_count_next = value_count_reg;
        min_count_next   = min_count_reg;
        if (cmd.exec)
        begin
            if (push_ok)
                value_count_next = value_count_reg + CW'(1);
            else if (pop_ok)
                value_count_next = value_count_reg - CW'(1);
            if (push_min)
                min_count_next = min_count_reg + CW'(1);
            else if (pop_min)
                min_count_next = min_count_reg - CW'(1);
        end

        // Entries that hold the tops once the pop has taken effect.
        val_rd_count = value_count_reg - CW'(2);
        min_rd_count = pop_min ? (min_count_reg - CW'(2)) : (min_count_reg - CW'(1));
    end

    assign sts.refetch = pop_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= '0;
            min_count_reg   <= '0;
        end
        else
        begin
            value_count_reg <= value_count_next;
            min_count_reg   <= min_count_next;
        end
    end

    // Memories: one write and one registered read each.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_ok)
            value_mem[value_count_reg[AW-1:0]] <= val_reg;
        val_rd_reg <= value_mem[val_rd_count[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && push_min)
            min_mem[min_count_reg[AW-1:0]] <= val_reg;
        min_rd_reg <= min_mem[min_rd_count[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= operation;
            val_reg <= push_value;
        end
        if (cmd.exec)
        begin
            if (op_reg == OP_PUSH && full)
                status_reg <= ST_OVERFLOW;
            else if (op_reg == OP_POP && empty)
                status_reg <= ST_UNDERFLOW;
            else
                status_reg <= ST_OK;
        end
        if (cmd.exec && push_ok)
            top_reg <= val_reg;
        else if (cmd.load)
            top_reg <= val_rd_reg;
        if (cmd.exec && push_min)
            min_top_reg <= val_reg;
        else if (cmd.load)
            min_top_reg <= min_rd_reg;
        if (cmd.emit)
        begin
            top_out_reg    <= empty ? '0 : top_reg;
            min_out_reg    <= min_empty ? '0 : min_top_reg;
            empty_out_reg  <= empty;
            status_out_reg <= status_reg;
        end
    end

    assign top_value = top_out_reg;
    assign min_value = min_out_reg;
    assign is_empty  = empty_out_reg;
    assign status    = status_out_reg;

    `MSK_ASSERT(a_min_within_values, min_count_reg <= value_count_reg)
    `MSK_ASSERT(a_count_bounded, value_count_reg <= FULL_COUNT)
    `MSK_ASSERT_NEXT(a_pop_never_grows_min, cmd.exec && op_reg == OP_POP,
        min_count_reg <= $past(min_count_reg))
    `MSK_ASSERT_NEXT(a_push_counts_up, cmd.exec && op_reg == OP_PUSH && !full,
        value_count_reg == $past(value_count_reg) + CW'(1))

endmodule

// File: rtl/core/msk_controller.sv
// Controller state machine of the min stack: sequences capture, update,
// refetch and output. Depends on msk_pkg.
module msk_controller import msk_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output msk_cmd_t cmd,
    input  msk_sts_t sts
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXEC   = 4'b0010,
        S_LOAD   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_ready    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = sts.refetch ? S_LOAD : S_FINISH;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // The output register takes the word once it is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/min_tracking_stack_core.sv
// Top level of the min stack core: controller plus datapath behind two channels.
// Depends on msk_pkg, msk_req_if, msk_rsp_if, msk_controller and msk_datapath.
//
// This core is a last-in first-out stack of signed 32-bit values that also
// tracks the smallest value it holds. Each request word is a push or a pop,
// and each one returns exactly one response word with the new top, the
// current minimum (both zero when the stack is empty), an empty flag and a
// status: ok, overflow when a push finds the stack full (nothing changes),
// or underflow when a pop finds it empty (nothing changes). Values live in
// a main memory of STACK_DEPTH entries; a second memory of the same depth
// holds the chain of minima, which grows when a pushed value is less than or
// equal to the current minimum and shrinks when the popped value equals it.
// The top of each memory is cached in a register, so a push goes from
// acceptance through the execute and finish states to the response word,
// and a successful pop also passes a load state, the registered read that
// refetches the new tops from both memories. One request is worked on at a
// time; the response sits in an output register, so the next request is
// accepted while the previous response waits to be taken. No clearing pass
// is needed after reset: only entries below the fill counts reach a response.
module min_tracking_stack_core import msk_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    msk_req_if.sink   req,
    msk_rsp_if.source rsp
);

    msk_cmd_t cmd;
    msk_sts_t sts;

    msk_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    msk_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .operation  (req.operation),
        .push_value (req.push_value),
        .top_value  (rsp.top_value),
        .min_value  (rsp.min_value),
        .is_empty   (rsp.is_empty),
        .status     (rsp.status)
    );

endmodule
